// ===== rtl/smpcf_pkg.sv =====
// Shared constants, codes and types of the shadow map PCF sampler.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package smpcf_pkg;

    localparam int MAP_BITS  = 10;
    localparam int MAP_WIDTH = 1 << MAP_BITS;
    localparam int ADDR_W    = 2 * MAP_BITS;
    localparam int BANK_AW   = ADDR_W - 2;
    localparam int TEXEL_W   = 16;
    localparam int MAT_W     = 32;
    localparam int PROJ_W    = 50;
    localparam int MAG_W     = 49;
    localparam int NUM_W     = 73;
    localparam int Q_W       = 30;
    localparam int CMP_W     = MAG_W + Q_W;
    localparam int U_W       = 32;
    localparam int D_W       = 26;
    localparam int DQ_W      = 24;
    localparam int CB_W      = 16;
    localparam int DB_W      = 24;
    localparam int VIS_W     = 17;
    localparam int WGT_W     = 17;
    localparam int TERM_W    = 25;

    localparam logic [1:0] MODE_TEXEL  = 2'd0;
    localparam logic [1:0] MODE_MATRIX = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] CFG_COORD_BIAS = 2'd0;
    localparam logic [1:0] CFG_DEPTH_BIAS = 2'd1;
    localparam logic [1:0] CFG_USE_MAP    = 2'd2;
    localparam logic [1:0] CFG_MAP_LOADED = 2'd3;

    localparam logic signed [CB_W-1:0]  COORD_BIAS_RST = -16'sd128;
    localparam logic signed [DB_W-1:0]  DEPTH_BIAS_RST = -24'sd10240;
    localparam logic signed [MAT_W-1:0] MAT_ONE        = 32'sd65536;
    localparam logic [VIS_W-1:0]        FULL_VIS       = 17'h10000;
    localparam logic [DQ_W-1:0]         DEPTH_MAX_Q8   = DQ_W'(65535 * 256);
    localparam logic [Q_W:0]            COORD_SAT      = (Q_W+1)'(1) << Q_W;

    // sideband that travels alongside the projection and divide pipeline
    typedef struct packed {
        logic               qv;
        logic               wv;
        logic [ADDR_W-1:0]  widx;
        logic [TEXEL_W-1:0] wdat;
        logic               full;
        logic               negx;
        logic               negy;
        logic               satx;
        logic               saty;
        logic               zzero;
        logic               zge;
    } t_side;

    // one query as it enters the filter, aligned with the texel read data
    typedef struct packed {
        logic                  qv;
        logic                  full;
        logic [7:0]            fx;
        logic [7:0]            fy;
        logic                  xpar;
        logic                  ypar;
        logic signed [D_W-1:0] d;
    } t_smp;

endpackage

`default_nettype wire

// ===== rtl/smpcf_proj.sv =====
// Projection matrix registers and the 4x3 multiply-accumulate, two stages.
// Depends on smpcf_pkg.
`default_nettype none

module smpcf_proj (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_mat_we,
    input  logic [3:0]                             i_mat_idx,
    input  logic signed [smpcf_pkg::MAT_W-1:0]     i_mat_val,
    input  logic signed [smpcf_pkg::MAT_W-1:0]     i_px,
    input  logic signed [smpcf_pkg::MAT_W-1:0]     i_py,
    input  logic signed [smpcf_pkg::MAT_W-1:0]     i_pz,
    output logic signed [smpcf_pkg::PROJ_W-1:0]    o_proj [4]
);

    logic signed [smpcf_pkg::MAT_W-1:0]  r_mat [16];
    logic signed [smpcf_pkg::MAT_W-1:0]  pt [3];
    logic signed [2*smpcf_pkg::MAT_W-1:0] r_prod [4][3];
    logic signed [smpcf_pkg::MAT_W-1:0]  r_ofs [4];
    logic signed [smpcf_pkg::PROJ_W-1:0] r_proj [4];

    assign pt[0] = i_px;
    assign pt[1] = i_py;
    assign pt[2] = i_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_mat[k] <= (k % 5 == 0) ? smpcf_pkg::MAT_ONE : '0;
            end
        end else if (i_mat_we) begin
            r_mat[i_mat_idx] <= i_mat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= (2*smpcf_pkg::MAT_W)'(r_mat[i*4+j])
                              * (2*smpcf_pkg::MAT_W)'(pt[j]);
            end
            r_ofs[i] <= r_mat[i*4+3];
        end
    end

    // Q16.16 * Q16.16 products floored back to Q.16, then the w column added
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_proj[i] <= smpcf_pkg::PROJ_W'(r_prod[i][0] >>> 16)
                       + smpcf_pkg::PROJ_W'(r_prod[i][1] >>> 16)
                       + smpcf_pkg::PROJ_W'(r_prod[i][2] >>> 16)
                       + smpcf_pkg::PROJ_W'(r_ofs[i]);
        end
    end

    assign o_proj = r_proj;

endmodule

`default_nettype wire

// ===== rtl/smpcf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Valid while the quotient fits in Q_W bits. Depends on smpcf_pkg.
`default_nettype none

module smpcf_div (
    input  logic                           i_clk,
    input  logic [smpcf_pkg::NUM_W-1:0]    i_num,
    input  logic [smpcf_pkg::MAG_W-1:0]    i_den,
    output logic [smpcf_pkg::Q_W-1:0]      o_quo,
    output logic                           o_inexact
);

    logic [smpcf_pkg::NUM_W-1:0] r_rem [smpcf_pkg::Q_W];
    logic [smpcf_pkg::MAG_W-1:0] r_den [smpcf_pkg::Q_W];
    logic [smpcf_pkg::Q_W-1:0]   r_quo [smpcf_pkg::Q_W];

    for (genvar s = 0; s < smpcf_pkg::Q_W; s++) begin : g_step
        localparam int K = smpcf_pkg::Q_W - 1 - s;
        logic [smpcf_pkg::NUM_W-1:0] rem_in;
        logic [smpcf_pkg::MAG_W-1:0] den_in;
        logic [smpcf_pkg::Q_W-1:0]   quo_in;
        logic [smpcf_pkg::CMP_W-1:0] sub_den;
        logic [smpcf_pkg::CMP_W:0]   diff;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign sub_den = smpcf_pkg::CMP_W'(den_in) << K;
        assign diff    = {1'b0, smpcf_pkg::CMP_W'(rem_in)} - {1'b0, sub_den};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= diff[smpcf_pkg::CMP_W] ? rem_in : diff[smpcf_pkg::NUM_W-1:0];
            r_den[s] <= den_in;
            r_quo[s] <= {quo_in[smpcf_pkg::Q_W-2:0], ~diff[smpcf_pkg::CMP_W]};
        end
    end

    assign o_quo     = r_quo[smpcf_pkg::Q_W-1];
    assign o_inexact = (r_rem[smpcf_pkg::Q_W-1] != '0);

endmodule

`default_nettype wire

// ===== rtl/smpcf_depth_mem.sv =====
// Depth map store: four banks split by row and column parity, so that
// the four texels of one 2x2 footprint are read in parallel. Depends on smpcf_pkg.
`default_nettype none

module smpcf_depth_mem (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [smpcf_pkg::ADDR_W-1:0]                 i_waddr,
    input  logic [smpcf_pkg::TEXEL_W-1:0]                i_wdata,
    input  logic [3:0][smpcf_pkg::BANK_AW-1:0]           i_raddr,
    output logic [3:0][smpcf_pkg::TEXEL_W-1:0]           o_rdata
);

    logic [1:0]                    wbank;
    logic [smpcf_pkg::BANK_AW-1:0] wrow_col;

    assign wbank    = {i_waddr[smpcf_pkg::MAP_BITS], i_waddr[0]};
    assign wrow_col = {i_waddr[smpcf_pkg::ADDR_W-1:smpcf_pkg::MAP_BITS+1],
                       i_waddr[smpcf_pkg::MAP_BITS-1:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [smpcf_pkg::TEXEL_W-1:0] mem [1 << smpcf_pkg::BANK_AW];
        logic [smpcf_pkg::TEXEL_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_we && (wbank == BID)) begin
                mem[wrow_col] <= i_wdata;
            end
            r_q <= mem[i_raddr[b]];
        end

        assign o_rdata[b] = r_q;
    end

endmodule

`default_nettype wire

// ===== rtl/smpcf_filter.sv =====
// Bilinear percentage-closer filter: weights and depth tests, weighted
// terms, then the sum. Three stages. Depends on smpcf_pkg.
`default_nettype none

module smpcf_filter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  smpcf_pkg::t_smp                         i_smp,
    input  logic [3:0][smpcf_pkg::TEXEL_W-1:0]      i_rdata,
    output logic                                    o_valid,
    output logic [smpcf_pkg::VIS_W-1:0]             o_vis
);

    logic [smpcf_pkg::WGT_W-1:0]  r_wgt [4];
    logic [3:0]                   r_gt;
    logic [3:0]                   r_eq;
    logic [7:0]                   r_df;
    logic                         r_v1;
    logic                         r_f1;
    logic [smpcf_pkg::TERM_W-1:0] r_term [4];
    logic                         r_v2;
    logic                         r_f2;
    logic [smpcf_pkg::TERM_W+1:0] sum;
    logic                         r_valid;
    logic [smpcf_pkg::VIS_W-1:0]  r_vis;

    always_ff @(posedge i_clk) begin
        logic [1:0]                    bsel;
        logic [smpcf_pkg::TEXEL_W-1:0] tex;
        logic [8:0]                    wx;
        logic [8:0]                    wy;
        logic signed [smpcf_pkg::D_W:0] tex_q8;
        for (int t = 0; t < 4; t++) begin
            bsel   = {i_smp.ypar ^ t[1], i_smp.xpar ^ t[0]};
            tex    = i_rdata[bsel];
            wx     = t[0] ? 9'(i_smp.fx) : 9'd256 - 9'(i_smp.fx);
            wy     = t[1] ? 9'(i_smp.fy) : 9'd256 - 9'(i_smp.fy);
            tex_q8 = signed'((smpcf_pkg::D_W+1)'({tex, 8'h00}));
            r_wgt[t] <= smpcf_pkg::WGT_W'(wx) * smpcf_pkg::WGT_W'(wy);
            r_gt[t]  <= tex_q8 > (smpcf_pkg::D_W+1)'(signed'(i_smp.d));
            // equality against the integer part, only for non-negative depth
            r_eq[t]  <= !i_smp.d[smpcf_pkg::D_W-1]
                     && (i_smp.d[smpcf_pkg::D_W-1:8] == (smpcf_pkg::D_W-8)'(tex));
        end
        r_df <= i_smp.d[7:0];
        r_f1 <= i_smp.full;
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < 4; t++) begin
            if (r_gt[t]) begin
                r_term[t] <= smpcf_pkg::TERM_W'(r_wgt[t]) << 8;
            end else if (r_eq[t]) begin
                r_term[t] <= smpcf_pkg::TERM_W'(r_wgt[t])
                           * smpcf_pkg::TERM_W'(9'd256 - 9'(r_df));
            end else begin
                r_term[t] <= '0;
            end
        end
        r_f2 <= r_f1;
    end

    assign sum = (smpcf_pkg::TERM_W+2)'(r_term[0]) + (smpcf_pkg::TERM_W+2)'(r_term[1])
               + (smpcf_pkg::TERM_W+2)'(r_term[2]) + (smpcf_pkg::TERM_W+2)'(r_term[3]);

    always_ff @(posedge i_clk) begin
        r_vis <= r_f2 ? smpcf_pkg::FULL_VIS : sum[smpcf_pkg::VIS_W+7:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_smp.qv;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
    end

    assign o_valid = r_valid;
    assign o_vis   = r_vis;

endmodule

`default_nettype wire

// ===== rtl/shadow_map_pcf_sampler_core.sv =====
// Shadow map PCF sampler top: one item accepted every cycle, busy stays low.
// A query's visibility strobes on o_valid after the projection, divide, depth read
// and filter stages; a texel write lands in the banked depth store in order with
// the queries; the 30-stage divider accounts for most of the pipeline depth.
// Synchronous active-low reset clears config to defaults and the matrix to
// identity; the depth store is not cleared. Depends on smpcf_pkg and all smpcf_*.
`default_nettype none

module shadow_map_pcf_sampler_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_mode,
    input  logic [smpcf_pkg::ADDR_W-1:0]          i_texel_index,
    input  logic [smpcf_pkg::TEXEL_W-1:0]         i_texel_depth,
    input  logic [3:0]                            i_matrix_index,
    input  logic signed [smpcf_pkg::MAT_W-1:0]    i_matrix_value,
    input  logic signed [smpcf_pkg::MAT_W-1:0]    i_point_x,
    input  logic signed [smpcf_pkg::MAT_W-1:0]    i_point_y,
    input  logic signed [smpcf_pkg::MAT_W-1:0]    i_point_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [smpcf_pkg::DB_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic [smpcf_pkg::VIS_W-1:0]           o_visibility
);

    localparam int XW = smpcf_pkg::MAG_W + 12;

    logic                                accept;
    logic signed [smpcf_pkg::CB_W-1:0]   r_cb;
    logic signed [smpcf_pkg::DB_W-1:0]   r_db;
    logic                                r_use;
    logic                                r_loaded;

    smpcf_pkg::t_side                    r_s1, r_s2, r_s3, r_s4;
    smpcf_pkg::t_side                    n_s1, n_s3, n_s4;
    smpcf_pkg::t_side                    r_dly [smpcf_pkg::Q_W];
    logic signed [smpcf_pkg::PROJ_W-1:0] proj [4];
    logic [smpcf_pkg::MAG_W-1:0]         r_mx, r_my, r_mz, r_mw;
    logic [smpcf_pkg::NUM_W-1:0]         r_numx, r_numy, r_numz;
    logic [smpcf_pkg::MAG_W-1:0]         r_den;
    logic [smpcf_pkg::Q_W-1:0]           quox, quoy, quoz;
    logic                                inexx, inexy, inexz;

    logic                                r_pqv, r_pwv, r_pfull;
    logic [smpcf_pkg::ADDR_W-1:0]        r_pwidx;
    logic [smpcf_pkg::TEXEL_W-1:0]       r_pwdat;
    logic signed [smpcf_pkg::U_W-1:0]    r_u, r_v;
    logic signed [smpcf_pkg::D_W-1:0]    r_d;

    logic [smpcf_pkg::MAP_BITS-1:0]      xi, yi;
    logic [3:0][smpcf_pkg::BANK_AW-1:0]  raddr;
    logic [3:0][smpcf_pkg::TEXEL_W-1:0]  rdata;
    smpcf_pkg::t_smp                     r_smp;

    function automatic logic [smpcf_pkg::MAG_W-1:0] mag_of(
        input logic signed [smpcf_pkg::PROJ_W-1:0] p);
        logic signed [smpcf_pkg::PROJ_W-1:0] a;
        a = p[smpcf_pkg::PROJ_W-1] ? -p : p;
        return a[smpcf_pkg::MAG_W-1:0];
    endfunction

    function automatic logic signed [smpcf_pkg::U_W-1:0] coord_q8(
        input logic [smpcf_pkg::Q_W-1:0] quo, input logic inexact,
        input logic neg, input logic sat, input logic signed [smpcf_pkg::CB_W-1:0] cb);
        logic [smpcf_pkg::Q_W:0]          m;
        logic signed [smpcf_pkg::U_W-1:0] sm;
        m  = sat ? smpcf_pkg::COORD_SAT
                 : (smpcf_pkg::Q_W+1)'(quo) + (smpcf_pkg::Q_W+1)'(neg & inexact);
        sm = signed'(smpcf_pkg::U_W'(m));
        return (neg ? -sm : sm) + smpcf_pkg::U_W'(cb);
    endfunction

    function automatic logic [smpcf_pkg::MAP_BITS-1:0] clamp_tl(
        input logic signed [smpcf_pkg::U_W-1:0] u);
        logic signed [smpcf_pkg::U_W-1:0] t;
        t = u >>> 8;
        if (t < 0) begin
            return '0;
        end else if (t > signed'(smpcf_pkg::U_W'(smpcf_pkg::MAP_WIDTH - 2))) begin
            return smpcf_pkg::MAP_BITS'(smpcf_pkg::MAP_WIDTH - 2);
        end else begin
            return t[smpcf_pkg::MAP_BITS-1:0];
        end
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb     <= smpcf_pkg::COORD_BIAS_RST;
            r_db     <= smpcf_pkg::DEPTH_BIAS_RST;
            r_use    <= 1'b1;
            r_loaded <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smpcf_pkg::CFG_COORD_BIAS: r_cb     <= i_cfg_data[smpcf_pkg::CB_W-1:0];
                smpcf_pkg::CFG_DEPTH_BIAS: r_db     <= i_cfg_data;
                smpcf_pkg::CFG_USE_MAP:    r_use    <= i_cfg_data[0];
                smpcf_pkg::CFG_MAP_LOADED: r_loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    smpcf_proj u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mat_we  (accept && (i_mode == smpcf_pkg::MODE_MATRIX)),
        .i_mat_idx (i_matrix_index),
        .i_mat_val (i_matrix_value),
        .i_px      (i_point_x),
        .i_py      (i_point_y),
        .i_pz      (i_point_z),
        .o_proj    (proj)
    );

    always_comb begin
        n_s1      = '0;
        n_s1.qv   = accept && (i_mode == smpcf_pkg::MODE_QUERY);
        n_s1.wv   = accept && (i_mode == smpcf_pkg::MODE_TEXEL);
        n_s1.widx = i_texel_index;
        n_s1.wdat = i_texel_depth;
    end

    // projection stage flags, then magnitudes, then dividends and range tests
    always_comb begin
        n_s3       = r_s2;
        n_s3.full  = !r_use || !r_loaded || (proj[3] == '0);
        n_s3.negx  = (proj[0] != '0) && (proj[0][smpcf_pkg::PROJ_W-1] ^ proj[3][smpcf_pkg::PROJ_W-1]);
        n_s3.negy  = (proj[1] != '0) && (proj[1][smpcf_pkg::PROJ_W-1] ^ proj[3][smpcf_pkg::PROJ_W-1]);
        n_s3.zzero = (proj[2] == '0) || (proj[2][smpcf_pkg::PROJ_W-1] ^ proj[3][smpcf_pkg::PROJ_W-1]);

        n_s4      = r_s3;
        n_s4.satx = XW'(r_mx) >= (XW'(r_mw) << 12);
        n_s4.saty = XW'(r_my) >= (XW'(r_mw) << 12);
        n_s4.zge  = r_mz >= r_mw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            for (int k = 0; k < smpcf_pkg::Q_W; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            r_s1      <= n_s1;
            r_s2      <= r_s1;
            r_s3      <= n_s3;
            r_s4      <= n_s4;
            r_dly[0]  <= r_s4;
            for (int k = 1; k < smpcf_pkg::Q_W; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx   <= mag_of(proj[0]);
        r_my   <= mag_of(proj[1]);
        r_mz   <= mag_of(proj[2]);
        r_mw   <= mag_of(proj[3]);
        r_numx <= smpcf_pkg::NUM_W'(r_mx) << 18;
        r_numy <= smpcf_pkg::NUM_W'(r_my) << 18;
        // |z| * 65535 in Q.8
        r_numz <= (smpcf_pkg::NUM_W'(r_mz) << 24) - (smpcf_pkg::NUM_W'(r_mz) << 8);
        r_den  <= r_mw;
    end

    smpcf_div u_div_x (.i_clk(i_clk), .i_num(r_numx), .i_den(r_den),
                       .o_quo(quox), .o_inexact(inexx));
    smpcf_div u_div_y (.i_clk(i_clk), .i_num(r_numy), .i_den(r_den),
                       .o_quo(quoy), .o_inexact(inexy));
    smpcf_div u_div_z (.i_clk(i_clk), .i_num(r_numz), .i_den(r_den),
                       .o_quo(quoz), .o_inexact(inexz));

    always_ff @(posedge i_clk) begin
        logic [smpcf_pkg::DQ_W-1:0] dq;
        smpcf_pkg::t_side           sd;
        sd = r_dly[smpcf_pkg::Q_W-1];
        if (sd.zzero) begin
            dq = '0;
        end else if (sd.zge) begin
            dq = smpcf_pkg::DEPTH_MAX_Q8;
        end else begin
            dq = quoz[smpcf_pkg::DQ_W-1:0];
        end
        r_u     <= coord_q8(quox, inexx, sd.negx, sd.satx, r_cb);
        r_v     <= coord_q8(quoy, inexy, sd.negy, sd.saty, r_cb);
        r_d     <= signed'(smpcf_pkg::D_W'(dq)) + smpcf_pkg::D_W'(r_db);
        r_pwidx <= sd.widx;
        r_pwdat <= sd.wdat;
        r_pfull <= sd.full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pqv <= 1'b0;
            r_pwv <= 1'b0;
        end else begin
            r_pqv <= r_dly[smpcf_pkg::Q_W-1].qv;
            r_pwv <= r_dly[smpcf_pkg::Q_W-1].wv;
        end
    end

    // each bank holds the footprint texel whose row and column parity match it
    assign xi = clamp_tl(r_u);
    assign yi = clamp_tl(r_v);

    always_comb begin
        logic [smpcf_pkg::MAP_BITS-1:0] row;
        logic [smpcf_pkg::MAP_BITS-1:0] col;
        for (int b = 0; b < 4; b++) begin
            row = (yi[0] == b[1]) ? yi : yi + 1'b1;
            col = (xi[0] == b[0]) ? xi : xi + 1'b1;
            raddr[b] = {row[smpcf_pkg::MAP_BITS-1:1], col[smpcf_pkg::MAP_BITS-1:1]};
        end
    end

    smpcf_depth_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (r_pwv),
        .i_waddr (r_pwidx),
        .i_wdata (r_pwdat),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_smp.full <= r_pfull;
        r_smp.fx   <= r_u[7:0];
        r_smp.fy   <= r_v[7:0];
        r_smp.xpar <= xi[0];
        r_smp.ypar <= yi[0];
        r_smp.d    <= r_d;
        if (!i_rst_n) begin
            r_smp.qv <= 1'b0;
        end else begin
            r_smp.qv <= r_pqv;
        end
    end

    smpcf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (r_smp),
        .i_rdata (rdata),
        .o_valid (o_valid),
        .o_vis   (o_visibility)
    );

endmodule

`default_nettype wire
